/* design/frame_deadline_pacer_macros.svh */
// Assertion macros shared by the pacer RTL.
`ifndef FRAME_DEADLINE_PACER_MACROS_SVH
`define FRAME_DEADLINE_PACER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDP_ASSERT(label, prop, msg)
`define FDP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/fdp_pkg.sv */
package fdp_pkg;

  localparam int CENSUS_WINDOW = 600;
  localparam int FRACTION_BITS = 16;
  localparam int TICK_BITS = 48;

  localparam int FREQ_W = 32;
  localparam int NOW_W = 48;
  localparam int RATE_W = 16;
  localparam int WAIT_W = 32;
  localparam int SUM_W = 42;
  localparam int CNT_W = 10;
  localparam int DL_W = 64;
  localparam int OUTCOME_W = 2;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
  localparam logic [CNT_W-1:0] CENSUS_COUNT = CNT_W'(CENSUS_WINDOW);
  localparam logic [NOW_W-1:0] TICK_MASK = {NOW_W{1'b1}} >> (NOW_W - TICK_BITS);

  localparam int DIV_W = (FREQ_W + FRACTION_BITS > SUM_W) ? FREQ_W + FRACTION_BITS : SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [OUTCOME_W-1:0] OUTCOME_CLEAR = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REARM = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_LATE = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_PACED = 2'd3;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                               input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
  endfunction

  function automatic logic [WAIT_W-1:0] ceil_ticks(input logic [DL_W-1:0] diff);
    logic [DL_W:0] q;
    q = ({1'b0, diff} + (DL_W+1)'((65'd1 << FRACTION_BITS) - 65'd1)) >> FRACTION_BITS;
    return (q[DL_W:WAIT_W] != '0) ? {WAIT_W{1'b1}} : q[WAIT_W-1:0];
  endfunction

endpackage

/* design/fdp_div.sv */
module fdp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  fdp_pkg::div_req_t                 req,
  output logic                              busy,
  output logic                              done,
  output logic [fdp_pkg::DIV_W-1:0]         quotient
);
  import fdp_pkg::*;

  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W:0] trial;
  logic ge;
  logic [RATE_W:0] diff;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, quo[DIV_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

/* design/frame_deadline_pacer.sv */
// Frame deadline pacer.
// One input transaction on the s_ side is one frame request: a timestamp,
// the requested frame rate and a bypass flag. Each request produces exactly
// one result transaction on the m_ side with the outcome, the hold time in
// ticks and the wait statistics. The counter frequency register is written
// through cfg_we and cfg_wdata; the user must write it only while the block
// is idle, as the block itself does not enforce this. A request that clears
// or re-arms the pacer passes S_CHECK and then S_OUT. The shared restoring
// divider retires one quotient bit per cycle across its 48-bit quotient and
// runs once for the frame interval and again for the mean, so a late request
// also passes S_DIV_INT, S_ADD_T, S_ADD_B and S_CMP before S_OUT, and a paced
// request further passes S_WAIT, S_UPD and S_DIV_MEAN.
// s_tready is high only while no request is being worked on. A finished
// result waits in the output register; when the receiver stalls, the block
// still accepts and works out one more request, then holds it and takes no
// further request until the waiting result has been taken.
// Reset clears all pacer state and statistics, drops m_tvalid and sets the
// counter frequency to ten million ticks per second.
`include "frame_deadline_pacer_macros.svh"

module frame_deadline_pacer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  // now_ticks [47:0], frame_rate [63:48]
  input  logic [63:0]   s_tdata,
  // bypass [0]
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // wait_ticks [31:0], last_wait [63:32], mean_wait [95:64],
  // worst_wait [127:96], sample_count [137:128], zero fill [143:138]
  output logic [143:0]  m_tdata,
  // outcome [1:0], census_done [2]
  output logic [2:0]    m_tuser
);
  import fdp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV_INT = 4'd2;
  localparam logic [3:0] S_ADD_T = 4'd3;
  localparam logic [3:0] S_ADD_B = 4'd4;
  localparam logic [3:0] S_CMP = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_UPD = 4'd7;
  localparam logic [3:0] S_DIV_MEAN = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0] state;
  logic [FREQ_W-1:0] counter_frequency;
  logic [NOW_W-1:0] now_r;
  logic [RATE_W-1:0] rate_r;
  logic bypass_r;

  logic [DL_W-1:0] deadline;
  logic armed;
  logic [RATE_W-1:0] active_rate;
  logic [WAIT_W-1:0] last_wait_reg;
  logic [SUM_W-1:0] wait_sum;
  logic [CNT_W-1:0] sample_counter;
  logic [WAIT_W-1:0] mean_wait_reg;
  logic [WAIT_W-1:0] worst_wait_reg;

  logic [DIV_W-1:0] interval;
  logic [DL_W-1:0] target;
  logic [DL_W-1:0] bound;
  logic [DL_W-1:0] diff;
  logic [WAIT_W-1:0] wait_val;
  logic [OUTCOME_W-1:0] outcome_r;

  logic [DL_W-1:0] nowf;
  logic [DL_W-1:0] interval_ext;
  logic clear_req;
  logic rearm_req;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W-1:0] sum_next;
  logic census;
  logic out_free;

  div_req_t div_req;
  logic div_busy;
  logic div_done;
  logic [DIV_W-1:0] div_quot;

  assign nowf = DL_W'(now_r) << FRACTION_BITS;
  assign interval_ext = DL_W'(interval);
  assign clear_req = bypass_r || (rate_r == '0) || (counter_frequency == '0);
  assign rearm_req = !armed || (active_rate != rate_r);
  assign count_next = sample_counter + 1'b1;
  assign sum_next = wait_sum + SUM_W'(wait_val);
  assign census = (outcome_r == OUTCOME_PACED) && (sample_counter >= CENSUS_COUNT);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = DIV_W'(counter_frequency) << FRACTION_BITS;
    div_req.divisor = rate_r;
    if (state == S_CHECK && !clear_req && !rearm_req) begin
      div_req.start = 1'b1;
    end else if (state == S_UPD && count_next != '0) begin
      div_req.start = 1'b1;
      div_req.dividend = DIV_W'(sum_next);
      div_req.divisor = RATE_W'(count_next);
    end
  end

  fdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_frequency <= FREQ_RESET;
    end else if (cfg_we) begin
      counter_frequency <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      now_r <= s_tdata[NOW_W-1:0] & TICK_MASK;
      rate_r <= s_tdata[NOW_W+RATE_W-1:NOW_W];
      bypass_r <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      deadline <= '0;
      armed <= 1'b0;
      active_rate <= '0;
      last_wait_reg <= '0;
      wait_sum <= '0;
      sample_counter <= '0;
      mean_wait_reg <= '0;
      worst_wait_reg <= '0;
      outcome_r <= OUTCOME_CLEAR;
      wait_val <= '0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          wait_val <= '0;
          if (clear_req) begin
            deadline <= '0;
            armed <= 1'b0;
            active_rate <= '0;
            last_wait_reg <= '0;
            wait_sum <= '0;
            sample_counter <= '0;
            mean_wait_reg <= '0;
            worst_wait_reg <= '0;
            outcome_r <= OUTCOME_CLEAR;
            state <= S_OUT;
          end else if (rearm_req) begin
            active_rate <= rate_r;
            deadline <= nowf;
            armed <= 1'b1;
            outcome_r <= OUTCOME_REARM;
            state <= S_OUT;
          end else begin
            state <= S_DIV_INT;
          end
        end
        S_DIV_INT: begin
          if (div_done) begin
            interval <= div_quot;
            state <= S_ADD_T;
          end
        end
        S_ADD_T: begin
          target <= sat_add(deadline, interval_ext);
          state <= S_ADD_B;
        end
        S_ADD_B: begin
          bound <= sat_add(target, interval_ext);
          state <= S_CMP;
        end
        S_CMP: begin
          if (nowf > bound) begin
            deadline <= nowf;
            outcome_r <= OUTCOME_LATE;
            state <= S_OUT;
          end else begin
            diff <= (target > nowf) ? target - nowf : '0;
            deadline <= target;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          wait_val <= ceil_ticks(diff);
          state <= S_UPD;
        end
        S_UPD: begin
          outcome_r <= OUTCOME_PACED;
          last_wait_reg <= wait_val;
          wait_sum <= sum_next;
          sample_counter <= count_next;
          if (wait_val > worst_wait_reg) begin
            worst_wait_reg <= wait_val;
          end
          state <= (count_next != '0) ? S_DIV_MEAN : S_OUT;
        end
        S_DIV_MEAN: begin
          if (div_done) begin
            mean_wait_reg <= div_quot[WAIT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (census) begin
              wait_sum <= '0;
              sample_counter <= '0;
              worst_wait_reg <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {6'd0, sample_counter, worst_wait_reg, mean_wait_reg, last_wait_reg,
                  (outcome_r == OUTCOME_PACED) ? wait_val : {WAIT_W{1'b0}}};
      m_tuser <= {census, outcome_r};
    end
  end

  `FDP_ASSERT(a_ready_div_idle, s_tready |-> !div_busy, "ready while divider busy")
  `FDP_ASSERT(a_census_paced, (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == OUTCOME_PACED),
    "census flagged on a result that was not paced")
  `FDP_ASSERT(a_wait_paced, (m_tvalid && m_tdata[31:0] != '0) |->
    (m_tuser[1:0] == OUTCOME_PACED), "nonzero wait on a result that was not paced")
  `FDP_ASSERT(a_count_bound, sample_counter <= CENSUS_COUNT, "sample count past census window")
  `FDP_ASSERT(a_done_in_div, div_done |-> (state == S_DIV_INT || state == S_DIV_MEAN),
    "divider finished outside a divide step")
  `FDP_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == S_IDLE && !m_tvalid),
    "block not idle after reset")

endmodule

/* bench/frame_deadline_pacer_test.sv */
module frame_deadline_pacer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 600;
  localparam int NPROBE = 24;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [WAIT_W-1:0] wait_ticks;
    logic [WAIT_W-1:0] last_wait;
    logic [WAIT_W-1:0] mean_wait;
    logic [WAIT_W-1:0] worst_wait;
    logic [CNT_W-1:0] sample_count;
    logic census;
  } pacer_result_t;

  typedef struct packed {
    logic set_freq;
    logic [FREQ_W-1:0] freq;
    logic [NOW_W-1:0] stamp;
    logic [RATE_W-1:0] rate;
    logic byp;
    logic known;
    logic [OUTCOME_W-1:0] outcome;
    logic [WAIT_W-1:0] hold;
  } probe_t;

  // Columns: frequency write, frequency, timestamp, rate, bypass,
  // outcome known, outcome, wait in ticks.
  localparam probe_t PROBES [NPROBE] = '{
    '{1'b0, 32'd0, 48'd1000, 16'd60, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'd1000, 16'd60, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd200000, 16'd60, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd0, 16'd60, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd5, 16'd60, 1'b1, 1'b1, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd0, 16'd60, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'd0, 16'd0, 1'b0, 1'b1, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd1, 16'hFFFF, 1'b0, 1'b1, OUTCOME_PACED, 32'hFFFF_FFFF},
    '{1'b0, 32'd0, 48'd16, 16'd1, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'd30000016, 16'd1, 1'b0, 1'b1, OUTCOME_LATE, 32'd0},
    '{1'b0, 32'd0, 48'd40000015, 16'd1, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd55000016, 16'd1, 1'b0, 1'b1, OUTCOME_PACED, 32'd0},
    '{1'b1, 32'd0, 48'd100, 16'd60, 1'b0, 1'b1, OUTCOME_CLEAR, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd1, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'hFFFF_FFFF_FFFF, 16'd1, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'hFFFF_FFFF_FFFE, 16'd1, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b1, 32'd1, 48'd50, 16'hFFFF, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'd50, 16'hFFFF, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd51, 16'hFFFF, 1'b0, 1'b0, OUTCOME_CLEAR, 32'd0},
    '{1'b0, 32'd0, 48'd51, 16'd1, 1'b0, 1'b1, OUTCOME_REARM, 32'd0},
    '{1'b0, 32'd0, 48'd52, 16'd1, 1'b1, 1'b1, OUTCOME_CLEAR, 32'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [FREQ_W-1:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [143:0] m_tdata;
  logic [2:0] m_tuser;

  // Shadow copy of the pacer state, advanced once per accepted request.
  logic [FREQ_W-1:0] freq_reg = FREQ_RESET;
  logic [DL_W-1:0] deadline_fx = '0;
  logic armed_q = 1'b0;
  logic [RATE_W-1:0] rate_q = '0;
  logic [WAIT_W-1:0] last_hold = '0;
  logic [WAIT_W-1:0] mean_hold = '0;
  logic [WAIT_W-1:0] worst_hold = '0;
  logic [SUM_W-1:0] hold_sum = '0;
  logic [CNT_W-1:0] paced_count = '0;

  pacer_result_t pending_results [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;
  bit hold_req = 1'b0;

  frame_deadline_pacer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  function automatic pacer_result_t pace_request(input logic [NOW_W-1:0] stamp,
                                                 input logic [RATE_W-1:0] rate,
                                                 input logic byp);
    pacer_result_t r;
    logic [DL_W-1:0] now_fx;
    logic [DL_W-1:0] period_fx;
    logic [DL_W-1:0] target_fx;
    logic [DL_W-1:0] limit_fx;
    logic [DL_W-1:0] gap_fx;
    logic [DL_W:0] total;
    logic [DL_W-FRACTION_BITS:0] ticks;
    r = '0;
    now_fx = DL_W'(stamp & TICK_MASK) << FRACTION_BITS;
    if (byp || rate == '0 || freq_reg == '0) begin
      deadline_fx = '0;
      armed_q = 1'b0;
      rate_q = '0;
      last_hold = '0;
      hold_sum = '0;
      paced_count = '0;
      mean_hold = '0;
      worst_hold = '0;
      r.outcome = OUTCOME_CLEAR;
    end else if (!armed_q || rate_q != rate) begin
      rate_q = rate;
      deadline_fx = now_fx;
      armed_q = 1'b1;
      r.outcome = OUTCOME_REARM;
    end else begin
      period_fx = (DL_W'(freq_reg) << FRACTION_BITS) / DL_W'(rate);
      total = (DL_W+1)'(deadline_fx) + (DL_W+1)'(period_fx);
      target_fx = total[DL_W] ? '1 : total[DL_W-1:0];
      total = (DL_W+1)'(target_fx) + (DL_W+1)'(period_fx);
      limit_fx = total[DL_W] ? '1 : total[DL_W-1:0];
      if (now_fx > limit_fx) begin
        deadline_fx = now_fx;
        r.outcome = OUTCOME_LATE;
      end else begin
        if (target_fx > now_fx) begin
          gap_fx = target_fx - now_fx;
          ticks = (DL_W-FRACTION_BITS+1)'(gap_fx >> FRACTION_BITS)
                  + (DL_W-FRACTION_BITS+1)'(gap_fx[FRACTION_BITS-1:0] != '0);
          r.wait_ticks = (ticks > (DL_W-FRACTION_BITS+1)'(32'hFFFF_FFFF)) ?
                         '1 : ticks[WAIT_W-1:0];
        end
        deadline_fx = target_fx;
        r.outcome = OUTCOME_PACED;
        last_hold = r.wait_ticks;
        hold_sum = hold_sum + SUM_W'(r.wait_ticks);
        paced_count = paced_count + 1'b1;
        if (paced_count != '0) mean_hold = WAIT_W'(hold_sum / paced_count);
        if (r.wait_ticks > worst_hold) worst_hold = r.wait_ticks;
      end
    end
    r.last_wait = last_hold;
    r.mean_wait = mean_hold;
    r.worst_wait = worst_hold;
    r.sample_count = paced_count;
    if (r.outcome == OUTCOME_PACED && paced_count >= CENSUS_COUNT) begin
      r.census = 1'b1;
      hold_sum = '0;
      paced_count = '0;
      worst_hold = '0;
    end
    return r;
  endfunction

  task automatic push_request(input logic [NOW_W-1:0] stamp, input logic [RATE_W-1:0] rate,
                              input logic byp, input logic known,
                              input logic [OUTCOME_W-1:0] k_outcome,
                              input logic [WAIT_W-1:0] k_hold);
    pacer_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rate, stamp};
    s_tuser <= byp;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    r = pace_request(stamp, rate, byp);
    if (known) begin
      r.outcome = k_outcome;
      r.wait_ticks = k_hold;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_frequency(input logic [FREQ_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    freq_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a steady stream of frames near the programmed rate; in mixed
  // phases about half the requests are bypasses, zero rates, random values
  // or timestamps that step backward.
  task automatic run_phase(input logic [FREQ_W-1:0] freq, input int count,
                           input bit mixed, input bit squeeze);
    logic [NOW_W-1:0] cursor;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] cur_rate;
    logic [FREQ_W-1:0] per;
    logic [63:0] step;
    logic byp;
    int roll;
    set_frequency(freq);
    if (squeeze) hold_req = 1'b1;
    cursor = NOW_W'({$urandom, $urandom} >> 17);
    cur_rate = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(1, 65535)) :
               RATE_W'($urandom_range(24, 240));
    for (int n = 0; n < count; n++) begin
      per = freq / FREQ_W'(cur_rate);
      if (per == '0) per = 1;
      roll = $urandom_range(0, 999);
      byp = 1'b0;
      if (mixed && roll < 450) begin
        rate = cur_rate;
        case ($urandom_range(0, 3))
          0: begin
            cursor = NOW_W'({$urandom, $urandom});
            rate = RATE_W'($urandom);
            byp = 1'($urandom);
          end
          1: byp = 1'b1;
          2: rate = '0;
          default: cursor = cursor - NOW_W'(64'(per) * $urandom_range(1, 8));
        endcase
      end else begin
        if (roll >= 995) cur_rate = RATE_W'($urandom_range(1, 480));
        rate = cur_rate;
        if (roll >= 980) begin
          step = 64'(per) * $urandom_range(3, 50);
        end else if (roll >= 680) begin
          step = 64'(per) * $urandom_range(16, 28) / 16;
        end else begin
          step = 64'(per) * $urandom_range(8, 15) / 16;
        end
        cursor = cursor + NOW_W'(step);
      end
      push_request(cursor, rate, byp, 1'b0, OUTCOME_CLEAR, '0);
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pacer_result_t seen;
    pacer_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.outcome = m_tuser[1:0];
      seen.census = m_tuser[2];
      seen.wait_ticks = m_tdata[31:0];
      seen.last_wait = m_tdata[63:32];
      seen.mean_wait = m_tdata[95:64];
      seen.worst_wait = m_tdata[127:96];
      seen.sample_count = m_tdata[137:128];
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transaction expected none, got %0h", $time, seen);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("outcome", 64'(want.outcome), 64'(seen.outcome));
        compare_field("wait_ticks", 64'(want.wait_ticks), 64'(seen.wait_ticks));
        compare_field("last_wait", 64'(want.last_wait), 64'(seen.last_wait));
        compare_field("mean_wait", 64'(want.mean_wait), 64'(seen.mean_wait));
        compare_field("worst_wait", 64'(want.worst_wait), 64'(seen.worst_wait));
        compare_field("sample_count", 64'(want.sample_count), 64'(seen.sample_count));
        compare_field("census_done", 64'(want.census), 64'(seen.census));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : result_sink
    int span;
    int mode;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = $urandom_range(1, 60);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NPROBE; i++) begin
      if (PROBES[i].set_freq) set_frequency(PROBES[i].freq);
      push_request(PROBES[i].stamp, PROBES[i].rate, PROBES[i].byp, PROBES[i].known,
                   PROBES[i].outcome, PROBES[i].hold);
    end
    // The first phase runs long enough without a clear to close a census window.
    run_phase(32'd10000000, 660, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 40, 1'b1, 1'b1);
    run_phase(32'd1, 30, 1'b1, 1'b0);
    run_phase(32'd0, 10, 1'b1, 1'b0);
    run_phase($urandom, 40, 1'b1, 1'b0);
    drain_results();
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
